### hw/rtl/spsat_pkg.sv
// Shared types, constants and helper functions of the stereo polynomial saturator.
package spsat_pkg;

    // Sample and stream widths
    localparam int SAMPLE_W = 24;
    localparam int TDATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;

    // Fixed-point format: Q3.40 magnitudes
    localparam int Q_FRAC    = 40;
    localparam int AX_SH     = Q_FRAC + 1 - SAMPLE_W;
    localparam int GAIN_FRAC = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_L = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_R = 3'd4;

    // Gain controls
    localparam int GAIN_W  = 17;
    localparam int DRIVE_W = 20;
    localparam logic [GAIN_W-1:0]  GAIN_MAX      = 17'd65536;
    localparam logic [DRIVE_W-1:0] DRIVE_MUL     = 20'd10;
    localparam logic [GAIN_W-1:0]  DRIVE_RESET   = 17'd6554;
    localparam logic [GAIN_W-1:0]  LEVEL_RESET   = 17'd65536;
    localparam logic [GAIN_W-1:0]  WET_RESET     = 17'd65536;

    // Internal datapath widths
    localparam int AM_W  = 42;
    localparam int S_W   = 43;
    localparam int H_W   = 41;
    localparam int MIX_W = 43;
    localparam int AMR_W = DRIVE_W + Q_FRAC + 1;
    localparam int DRY_P_W = GAIN_W + Q_FRAC + 1;
    localparam int FIN_W = MIX_W + 2;

    // Split multiplier geometry
    localparam int MQ_A_W  = S_W;
    localparam int MQ_B_W  = 42;
    localparam int MQ_LO_W = 21;
    localparam int MQ_HI_W = MQ_B_W - MQ_LO_W;
    localparam int MQ_P_W  = MQ_A_W + MQ_B_W - Q_FRAC;

    // Polynomial and gain constants in Q.40
    localparam int C11_W = 17;
    localparam logic [AM_W-1:0]  CLAMP_Q40 = 42'd2535395756831;
    localparam logic [H_W-1:0]   Q_ONE     = 41'd1099511627776;
    localparam logic [H_W-1:0]   C3_Q40    = 41'd183251937963;
    localparam logic [H_W-1:0]   C5_Q40    = 41'd15934951127;
    localparam logic [H_W-1:0]   C7_Q40    = 41'd434575835;
    localparam logic [H_W-1:0]   C9_Q40    = 41'd4887031;
    localparam logic [C11_W-1:0] C11_Q40   = 17'd110180;
    localparam logic [H_W-1:0]   OUT_Q40   = 41'd1015838792902;

    // Dither generator
    localparam int NOISE_W = 32;
    localparam int DK_W    = 17;
    localparam int DM_W    = 48;
    localparam logic [DK_W-1:0]    DITHER_K   = 17'd119779;
    localparam logic [NOISE_W-1:0] NOISE_MID  = 32'h7fffffff;
    localparam logic [NOISE_W-1:0] SEED_L_RST = 32'd2654435769;
    localparam logic [NOISE_W-1:0] SEED_R_RST = 32'd2246822507;

    // Leading-one search and dither shift
    localparam int GRP_W      = 8;
    localparam int GRP_N      = (MIX_W + GRP_W - 1) / GRP_W;
    localparam int LEN_W      = 4;
    localparam int BL_W       = 6;
    localparam int SH_W       = 7;
    localparam int SH_BASE    = 32 + Q_FRAC;
    localparam int SH_EMPTY   = 32;
    localparam int SH_LIMIT   = 64;
    localparam int SH_MIN     = SH_BASE - MIX_W;
    localparam int DV_W       = DM_W - SH_MIN + 1;
    localparam int SH_IDX_W   = $clog2(SH_LIMIT);

    // Pipeline depth of one lane
    localparam int LANE_LAT = 22;

    // Gain controls handed to each lane
    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic [GAIN_W-1:0]  level;
        logic [GAIN_W-1:0]  wet;
        logic [GAIN_W-1:0]  dry;
    } t_gain;

    // Gains above one are used as one.
    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
        return (g > GAIN_MAX) ? GAIN_MAX : g;
    endfunction

    // One step of the xorshift32 generator.
    function automatic logic [NOISE_W-1:0] xorshift32(input logic [NOISE_W-1:0] x);
        logic [NOISE_W-1:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

### hw/rtl/stereo_polynomial_saturator.sv
// Top level of the stereo polynomial saturator: configuration, lanes and output stage.
//
// Use: stereo frames enter on the s_axis channel, left sample in the low 24 bits
// and right sample above it; processed frames leave on m_axis in the same layout.
// Gains and dither seeds are written on the plain cfg port (index 0 drive, 1 output
// level, 2 wet fraction, 3 left seed, 4 right seed) while no item is in flight; a
// seed write also restarts that channel's dither generator.
// Each channel has its own lane, a 22-stage pipeline in which every Q.40 product
// of two wide operands is split over two stages of a shared multiplier form.
// A result passes the lane stages and then the output register once its item is
// accepted. Throughput: one item per clock cycle while the receiver takes results;
// the only loop in the design is the dither generator step.
// Reset clears the pipeline valid bits and the output valid flag, restores the
// register reset values and loads both generators with their reset seeds.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_axis tready falls until the waiting item is taken.
module stereo_polynomial_saturator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spsat_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [spsat_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // Fields from bit 0 up: sample_left, sample_right.
    input  logic [spsat_pkg::TDATA_W-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // Fields from bit 0 up: out_left, out_right.
    output logic [spsat_pkg::TDATA_W-1:0]     o_m_axis_tdata
);

    localparam int SW  = spsat_pkg::SAMPLE_W;
    localparam int LAT = spsat_pkg::LANE_LAT;

    logic [spsat_pkg::GAIN_W-1:0] r_drive;
    logic [spsat_pkg::GAIN_W-1:0] r_level;
    logic [spsat_pkg::GAIN_W-1:0] r_wet;
    logic [LAT-1:0]               r_vld;

    logic                         pipe_en;
    logic                         acc;
    logic                         seed_l_we;
    logic                         seed_r_we;
    logic [spsat_pkg::GAIN_W-1:0] wet_c;
    spsat_pkg::t_gain             gain;
    logic signed [SW-1:0]         res_left;
    logic signed [SW-1:0]         res_right;

    // The pipeline moves unless a finished item is waiting and not taken.
    assign pipe_en         = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = pipe_en;
    assign acc             = i_s_axis_tvalid && pipe_en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= spsat_pkg::DRIVE_RESET;
            r_level <= spsat_pkg::LEVEL_RESET;
            r_wet   <= spsat_pkg::WET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spsat_pkg::REG_DRIVE: r_drive <= i_cfg_data[spsat_pkg::GAIN_W-1:0];
                spsat_pkg::REG_LEVEL: r_level <= i_cfg_data[spsat_pkg::GAIN_W-1:0];
                spsat_pkg::REG_WET:   r_wet   <= i_cfg_data[spsat_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign seed_l_we = i_cfg_we && (i_cfg_idx == spsat_pkg::REG_SEED_L);
    assign seed_r_we = i_cfg_we && (i_cfg_idx == spsat_pkg::REG_SEED_R);

    // Clamped gains shared by both lanes.
    assign wet_c      = spsat_pkg::clamp_gain(r_wet);
    assign gain.drive = spsat_pkg::DRIVE_W'(spsat_pkg::clamp_gain(r_drive)) * spsat_pkg::DRIVE_MUL;
    assign gain.level = spsat_pkg::clamp_gain(r_level);
    assign gain.wet   = wet_c;
    assign gain.dry   = spsat_pkg::GAIN_MAX - wet_c;

    // Valid bits that follow the items through the lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[LAT-2:0], acc};
        end
    end

    spsat_lane u_lane_l (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_acc       (acc),
        .i_sample    (signed'(i_s_axis_tdata[SW-1:0])),
        .i_gain      (gain),
        .i_seed_we   (seed_l_we),
        .i_seed      (i_cfg_data[spsat_pkg::NOISE_W-1:0]),
        .i_seed_init (spsat_pkg::SEED_L_RST),
        .o_sample    (res_left)
    );

    spsat_lane u_lane_r (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_acc       (acc),
        .i_sample    (signed'(i_s_axis_tdata[2*SW-1:SW])),
        .i_gain      (gain),
        .i_seed_we   (seed_r_we),
        .i_seed      (i_cfg_data[spsat_pkg::NOISE_W-1:0]),
        .i_seed_init (spsat_pkg::SEED_R_RST),
        .o_sample    (res_right)
    );

    spsat_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_vld    (r_vld[LAT-1]),
        .i_left   (res_left),
        .i_right  (res_right),
        .o_tvalid (o_m_axis_tvalid),
        .o_tdata  (o_m_axis_tdata)
    );

    // A waiting, untaken result must block new items.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("item accepted while the output was stalled");

    // An item leaving the last lane stage shows up on the output.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pipe_en && r_vld[LAT-1]) |=> o_m_axis_tvalid)
        else $error("item lost between the lanes and the output register");

    // A bubble leaving the last lane stage produces no result.
    a_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pipe_en && !r_vld[LAT-1]) |=> !o_m_axis_tvalid)
        else $error("result produced without an item");

    // A frozen pipeline keeps its valid bits.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pipe_en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

endmodule

### hw/rtl/spsat_mulq.sv
// Two-stage Q.40 multiplier that forms a*b/2^40 from two narrow partial products.
module spsat_mulq (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [spsat_pkg::MQ_A_W-1:0]   i_a,
    input  logic [spsat_pkg::MQ_B_W-1:0]   i_b,
    output logic [spsat_pkg::MQ_P_W-1:0]   o_p
);

    localparam int LO_P_W = spsat_pkg::MQ_A_W + spsat_pkg::MQ_LO_W;
    localparam int HI_P_W = spsat_pkg::MQ_A_W + spsat_pkg::MQ_HI_W;
    localparam int FULL_W = spsat_pkg::MQ_A_W + spsat_pkg::MQ_B_W;

    logic [spsat_pkg::MQ_A_W-1:0]  r_a;
    logic [spsat_pkg::MQ_HI_W-1:0] r_bhi;
    logic [LO_P_W-1:0]             r_lo;
    logic [spsat_pkg::MQ_P_W-1:0]  r_p;
    logic [LO_P_W-1:0]             lo_c;
    logic [HI_P_W-1:0]             hi_c;
    logic [FULL_W-1:0]             full_c;

    // First stage: the low half of b times a.
    assign lo_c = LO_P_W'(i_a) * LO_P_W'(i_b[spsat_pkg::MQ_LO_W-1:0]);

    // Second stage: the high half, aligned and added, then the Q.40 truncation.
    assign hi_c   = HI_P_W'(r_a) * HI_P_W'(r_bhi);
    assign full_c = FULL_W'(r_lo) + (FULL_W'(hi_c) << spsat_pkg::MQ_LO_W);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= i_a;
            r_bhi <= i_b[spsat_pkg::MQ_B_W-1:spsat_pkg::MQ_LO_W];
            r_lo  <= lo_c;
            r_p   <= full_c[FULL_W-1:spsat_pkg::Q_FRAC];
        end
    end

    assign o_p = r_p;

endmodule

### hw/rtl/spsat_lane.sv
// One channel of the saturator: drive, clamp, polynomial, gains, mix, dither, rounding and saturation.
module spsat_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_acc,
    input  logic signed [spsat_pkg::SAMPLE_W-1:0] i_sample,
    input  spsat_pkg::t_gain                    i_gain,
    input  logic                                i_seed_we,
    input  logic [spsat_pkg::NOISE_W-1:0]       i_seed,
    input  logic [spsat_pkg::NOISE_W-1:0]       i_seed_init,
    output logic signed [spsat_pkg::SAMPLE_W-1:0] o_sample
);

    localparam int LAT = spsat_pkg::LANE_LAT;
    localparam int AMR_W_L = spsat_pkg::AMR_W;

    // Values that travel down the pipeline with the sample.
    typedef struct packed {
        logic                                             neg;
        logic [spsat_pkg::SAMPLE_W-1:0]                   xm;
        logic [spsat_pkg::AM_W-1:0]                       am;
        logic [spsat_pkg::S_W-1:0]                        s;
        logic [spsat_pkg::H_W-1:0]                        h;
        logic                                             dneg;
        logic [spsat_pkg::NOISE_W-1:0]                    dabs;
        logic [spsat_pkg::DM_W-1:0]                       dm;
        logic [spsat_pkg::MIX_W-1:0]                      v;
        logic [spsat_pkg::MIX_W-1:0]                      dry;
        logic [spsat_pkg::GRP_N-1:0][spsat_pkg::LEN_W-1:0] glen;
        logic [spsat_pkg::SH_W-1:0]                       sh;
        logic                                             shz;
        logic [spsat_pkg::DV_W-1:0]                       dv;
    } t_side;

    t_side r_sd [1:LAT];
    t_side n_sd [1:LAT];

    logic [spsat_pkg::NOISE_W-1:0] r_noise;
    logic [spsat_pkg::NOISE_W-1:0] n_noise;
    logic [spsat_pkg::NOISE_W-1:0] noise_step;

    logic [spsat_pkg::MQ_P_W-1:0] p_sq;
    logic [spsat_pkg::MQ_P_W-1:0] p7;
    logic [spsat_pkg::MQ_P_W-1:0] p5;
    logic [spsat_pkg::MQ_P_W-1:0] p3;
    logic [spsat_pkg::MQ_P_W-1:0] p1;
    logic [spsat_pkg::MQ_P_W-1:0] py;
    logic [spsat_pkg::MQ_P_W-1:0] po;
    logic [spsat_pkg::H_W-1:0]    h7;
    logic [spsat_pkg::H_W-1:0]    h5;
    logic [spsat_pkg::H_W-1:0]    h3;
    logic [spsat_pkg::H_W-1:0]    h1;

    // Dither generator: a seed write loads it, every accepted item steps it.
    assign noise_step = spsat_pkg::xorshift32(r_noise);

    always_comb begin
        n_noise = r_noise;
        if (i_seed_we) begin
            n_noise = i_seed;
        end else if (i_acc) begin
            n_noise = noise_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise <= i_seed_init;
        end else begin
            r_noise <= n_noise;
        end
    end

    // Horner coefficients between the multiplier stages.
    assign h7 = spsat_pkg::C7_Q40 - p7[spsat_pkg::H_W-1:0];
    assign h5 = spsat_pkg::C5_Q40 - p5[spsat_pkg::H_W-1:0];
    assign h3 = spsat_pkg::C3_Q40 - p3[spsat_pkg::H_W-1:0];
    assign h1 = spsat_pkg::Q_ONE  - p1[spsat_pkg::H_W-1:0];

    // Square of the clamped drive, then the polynomial, then the output gain.
    spsat_mulq u_sq (
        .i_clk (i_clk), .i_en (i_en),
        .i_a   (spsat_pkg::MQ_A_W'(r_sd[1].am)),
        .i_b   (spsat_pkg::MQ_B_W'(r_sd[1].am)),
        .o_p   (p_sq)
    );

    spsat_mulq u_m7 (
        .i_clk (i_clk), .i_en (i_en),
        .i_a   (spsat_pkg::MQ_A_W'(r_sd[4].s)),
        .i_b   (spsat_pkg::MQ_B_W'(r_sd[4].h)),
        .o_p   (p7)
    );

    spsat_mulq u_m5 (
        .i_clk (i_clk), .i_en (i_en),
        .i_a   (spsat_pkg::MQ_A_W'(r_sd[6].s)),
        .i_b   (spsat_pkg::MQ_B_W'(h7)),
        .o_p   (p5)
    );

    spsat_mulq u_m3 (
        .i_clk (i_clk), .i_en (i_en),
        .i_a   (spsat_pkg::MQ_A_W'(r_sd[8].s)),
        .i_b   (spsat_pkg::MQ_B_W'(h5)),
        .o_p   (p3)
    );

    spsat_mulq u_m1 (
        .i_clk (i_clk), .i_en (i_en),
        .i_a   (spsat_pkg::MQ_A_W'(r_sd[10].s)),
        .i_b   (spsat_pkg::MQ_B_W'(h3)),
        .o_p   (p1)
    );

    spsat_mulq u_my (
        .i_clk (i_clk), .i_en (i_en),
        .i_a   (spsat_pkg::MQ_A_W'(r_sd[12].am)),
        .i_b   (spsat_pkg::MQ_B_W'(h1)),
        .o_p   (py)
    );

    spsat_mulq u_mo (
        .i_clk (i_clk), .i_en (i_en),
        .i_a   (spsat_pkg::MQ_A_W'(py[spsat_pkg::AM_W-1:0])),
        .i_b   (spsat_pkg::MQ_B_W'(spsat_pkg::OUT_Q40)),
        .o_p   (po)
    );

    // Next values of the side pipeline; most stages only pass their item on.
    always_comb begin
        logic [spsat_pkg::SAMPLE_W-1:0]             xm_c;
        logic [AMR_W_L-1:0]                         am_p;
        logic [AMR_W_L-1:0]                         am_raw;
        logic [spsat_pkg::NOISE_W-1:0]              d_pos;
        logic [spsat_pkg::NOISE_W-1:0]              d_neg;
        logic [spsat_pkg::S_W+spsat_pkg::C11_W-1:0] s_c11;
        logic [spsat_pkg::AM_W+spsat_pkg::GAIN_W-1:0] lv_p;
        logic [spsat_pkg::MIX_W+spsat_pkg::GAIN_W-1:0] wet_p;
        logic [spsat_pkg::DRY_P_W-1:0]              dry_p;
        logic [spsat_pkg::GRP_N*spsat_pkg::GRP_W-1:0] padded;
        logic [spsat_pkg::GRP_W-1:0]                grp;
        logic [spsat_pkg::LEN_W-1:0]                len;
        logic [spsat_pkg::BL_W-1:0]                 bl;

        n_sd[1] = r_sd[1];
        for (int k = 2; k <= LAT; k++) begin
            n_sd[k] = r_sd[k-1];
        end

        // Stage 1: magnitude, drive gain and clamp; dither offset from the stepped state.
        n_sd[1].neg = i_sample[spsat_pkg::SAMPLE_W-1];
        xm_c = n_sd[1].neg ? (~i_sample + 1'b1) : i_sample;
        n_sd[1].xm = xm_c;
        am_p   = AMR_W_L'(xm_c) * AMR_W_L'(i_gain.drive);
        am_raw = (am_p << spsat_pkg::AX_SH) >> spsat_pkg::GAIN_FRAC;
        if (am_raw > AMR_W_L'(spsat_pkg::CLAMP_Q40)) begin
            n_sd[1].am = spsat_pkg::CLAMP_Q40;
        end else begin
            n_sd[1].am = am_raw[spsat_pkg::AM_W-1:0];
        end
        d_pos = noise_step - spsat_pkg::NOISE_MID;
        d_neg = spsat_pkg::NOISE_MID - noise_step;
        n_sd[1].dneg = (noise_step < spsat_pkg::NOISE_MID);
        n_sd[1].dabs = n_sd[1].dneg ? d_neg : d_pos;

        // Stage 2: scaled dither magnitude.
        n_sd[2].dm = spsat_pkg::DM_W'(r_sd[1].dabs) * spsat_pkg::DM_W'(spsat_pkg::DITHER_K);

        // Stage 4: square taken over, first Horner step with a short constant.
        n_sd[4].s = p_sq[spsat_pkg::S_W-1:0];
        s_c11 = (spsat_pkg::S_W + spsat_pkg::C11_W)'(p_sq[spsat_pkg::S_W-1:0])
              * (spsat_pkg::S_W + spsat_pkg::C11_W)'(spsat_pkg::C11_Q40);
        n_sd[4].h = spsat_pkg::C9_Q40 - spsat_pkg::H_W'(s_c11 >> spsat_pkg::Q_FRAC);

        // Stage 17: output level.
        lv_p = (spsat_pkg::AM_W + spsat_pkg::GAIN_W)'(po[spsat_pkg::AM_W-1:0])
             * (spsat_pkg::AM_W + spsat_pkg::GAIN_W)'(i_gain.level);
        n_sd[17].v = spsat_pkg::MIX_W'(lv_p >> spsat_pkg::GAIN_FRAC);

        // Stage 18: wet share of the processed signal and dry share of the input.
        wet_p = (spsat_pkg::MIX_W + spsat_pkg::GAIN_W)'(r_sd[17].v)
              * (spsat_pkg::MIX_W + spsat_pkg::GAIN_W)'(i_gain.wet);
        n_sd[18].v = spsat_pkg::MIX_W'(wet_p >> spsat_pkg::GAIN_FRAC);
        dry_p = spsat_pkg::DRY_P_W'(r_sd[17].xm) * spsat_pkg::DRY_P_W'(i_gain.dry);
        n_sd[18].dry = spsat_pkg::MIX_W'((dry_p << spsat_pkg::AX_SH) >> spsat_pkg::GAIN_FRAC);

        // Stage 19: both shares carry the sign of the input, so magnitudes add.
        n_sd[19].v = r_sd[18].v + r_sd[18].dry;

        // Stage 20: bit length inside each byte of the mix magnitude.
        padded = (spsat_pkg::GRP_N * spsat_pkg::GRP_W)'(r_sd[19].v);
        for (int g = 0; g < spsat_pkg::GRP_N; g++) begin
            grp = padded[g*spsat_pkg::GRP_W +: spsat_pkg::GRP_W];
            len = '0;
            for (int b = 0; b < spsat_pkg::GRP_W; b++) begin
                if (grp[b]) begin
                    len = spsat_pkg::LEN_W'(b + 1);
                end
            end
            n_sd[20].glen[g] = len;
        end

        // Stage 21: overall bit length and the dither shift it implies.
        bl = '0;
        for (int g = 0; g < spsat_pkg::GRP_N; g++) begin
            if (r_sd[20].glen[g] != '0) begin
                bl = spsat_pkg::BL_W'(g * spsat_pkg::GRP_W) + spsat_pkg::BL_W'(r_sd[20].glen[g]);
            end
        end
        if (bl == '0) begin
            n_sd[21].sh = spsat_pkg::SH_W'(spsat_pkg::SH_EMPTY);
        end else begin
            n_sd[21].sh = spsat_pkg::SH_W'(spsat_pkg::SH_BASE) - spsat_pkg::SH_W'(bl);
        end
        n_sd[21].shz = (n_sd[21].sh >= spsat_pkg::SH_W'(spsat_pkg::SH_LIMIT));

        // Stage 22: dither value scaled to the mix magnitude.
        if (r_sd[21].shz) begin
            n_sd[22].dv = '0;
        end else begin
            n_sd[22].dv = spsat_pkg::DV_W'(r_sd[21].dm >> r_sd[21].sh[spsat_pkg::SH_IDX_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd <= n_sd;
        end
    end

    // Final add of the dither, rounding half away from zero and saturation.
    always_comb begin
        logic signed [spsat_pkg::FIN_W-1:0] mv;
        logic signed [spsat_pkg::FIN_W-1:0] dv;
        logic signed [spsat_pkg::FIN_W-1:0] mix;
        logic [spsat_pkg::FIN_W-1:0]        mag;
        logic [spsat_pkg::FIN_W-1:0]        rm;
        logic [spsat_pkg::FIN_W-1:0]        lim;

        mv  = signed'(spsat_pkg::FIN_W'(r_sd[LAT].v));
        dv  = signed'(spsat_pkg::FIN_W'(r_sd[LAT].dv));
        mix = (r_sd[LAT].neg ? -mv : mv) + (r_sd[LAT].dneg ? -dv : dv);
        mag = (mix < 0) ? unsigned'(-mix) : unsigned'(mix);
        rm  = (mag + (spsat_pkg::FIN_W'(1) << (spsat_pkg::AX_SH - 1))) >> spsat_pkg::AX_SH;
        lim = spsat_pkg::FIN_W'(1) << (spsat_pkg::SAMPLE_W - 1);
        if (mix < 0) begin
            if (rm > lim) begin
                rm = lim;
            end
            rm = ~rm + 1'b1;
        end else begin
            if (rm > lim - 1'b1) begin
                rm = lim - 1'b1;
            end
        end
        o_sample = signed'(rm[spsat_pkg::SAMPLE_W-1:0]);
    end

endmodule

### hw/rtl/spsat_merge.sv
// Output stage that joins the two channel results into one registered stereo item.
module spsat_merge (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic signed [spsat_pkg::SAMPLE_W-1:0] i_left,
    input  logic signed [spsat_pkg::SAMPLE_W-1:0] i_right,
    output logic                                  o_tvalid,
    // Fields from bit 0 up: out_left, out_right.
    output logic [spsat_pkg::TDATA_W-1:0]         o_tdata
);

    logic                          r_valid;
    logic [spsat_pkg::TDATA_W-1:0] r_data;

    // The valid flag is control state and resets; the data word does not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= spsat_pkg::TDATA_W'({i_right, i_left});
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;

endmodule

### tb/stereo_polynomial_saturator_tb.sv
// Self-checking testbench of the stereo polynomial saturator with a frame scoreboard.
`timescale 1ns / 1ps

module stereo_polynomial_saturator_tb;

    // Fixed-point constants of the saturator in Q.40.
    localparam longint K_ONE   = 64'sd1099511627776;
    localparam longint K_C3    = 64'sd183251937963;
    localparam longint K_C5    = 64'sd15934951127;
    localparam longint K_C7    = 64'sd434575835;
    localparam longint K_C9    = 64'sd4887031;
    localparam longint K_C11   = 64'sd110180;
    localparam longint K_OUT   = 64'sd1015838792902;
    localparam logic [63:0] K_CLAMP  = 64'd2535395756831;
    localparam logic [63:0] K_DITHER = 64'd119779;
    localparam logic [16:0] K_GAIN_ONE = 17'd65536;

    // An index that names no register.
    localparam logic [spsat_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [23:0] right;
        logic [23:0] left;
    } t_frame;

    // Predicts every output frame and checks the block's results in order.
    class saturator_scoreboard;
        logic [16:0] drive;
        logic [16:0] level;
        logic [16:0] wet;
        logic [31:0] noise [2];
        t_frame      expected_frames [$];
        int          errors;

        function new();
            drive    = 17'd6554;
            level    = 17'd65536;
            wet      = 17'd65536;
            noise[0] = 32'd2654435769;
            noise[1] = 32'd2246822507;
            errors   = 0;
        endfunction

        function void set_reg(logic [spsat_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                spsat_pkg::REG_DRIVE:  drive = data[16:0];
                spsat_pkg::REG_LEVEL:  level = data[16:0];
                spsat_pkg::REG_WET:    wet = data[16:0];
                spsat_pkg::REG_SEED_L: noise[0] = data;
                spsat_pkg::REG_SEED_R: noise[1] = data;
                default: ;
            endcase
        endfunction

        function logic [63:0] mag(longint v);
            logic [63:0] u;
            u = v;
            return (v < 0) ? -u : u;
        endfunction

        function longint with_sign(logic [63:0] m, bit neg);
            return neg ? -longint'(m) : longint'(m);
        endfunction

        // Truncated Q.40 product of two magnitudes.
        function logic [63:0] q40_mul(logic [63:0] x, logic [63:0] y);
            logic [127:0] p;
            p = {64'd0, x} * {64'd0, y};
            return p[103:40];
        endfunction

        function longint smul(longint x, longint y);
            return with_sign(q40_mul(mag(x), mag(y)), (x < 0) != (y < 0));
        endfunction

        function longint scale16(longint v, logic [63:0] k);
            return with_sign((mag(v) * k) >> 16, v < 0);
        endfunction

        function logic [63:0] limit_gain(logic [16:0] g);
            return {47'd0, (g > K_GAIN_ONE) ? K_GAIN_ONE : g};
        endfunction

        function logic [31:0] step_noise(logic [31:0] x);
            logic [31:0] t;
            t = x ^ (x << 13);
            t = t ^ (t >> 17);
            t = t ^ (t << 5);
            return t;
        endfunction

        // One channel: drive, clamp, polynomial, output gain, mix, dither, rounding.
        function logic [23:0] shape_sample(logic [23:0] raw, int ch);
            logic        neg;
            logic [63:0] xm, ax, am, mm, dm, dv, rm, wet_g;
            longint      dry, a, s, h, y, wp, dp, mix, d;
            int          bl, e, sh;
            neg = raw[23];
            xm  = neg ? ((64'd1 << 24) - {40'd0, raw}) : {40'd0, raw};
            ax  = xm << 17;
            dry = with_sign(ax, neg);
            am  = (ax * (limit_gain(drive) * 64'd10)) >> 16;
            if (am > K_CLAMP)
                am = K_CLAMP;
            a = with_sign(am, neg);
            s = longint'(q40_mul(am, am));
            // Horner form on the square of the clamped value.
            h = K_C11;
            h = K_C9 - smul(s, h);
            h = K_C7 - smul(s, h);
            h = K_C5 - smul(s, h);
            h = K_C3 - smul(s, h);
            h = K_ONE - smul(s, h);
            y = smul(a, h);
            wet_g = limit_gain(wet);
            wp  = scale16(scale16(smul(y, K_OUT), limit_gain(level)), wet_g);
            dp  = scale16(dry, 64'd65536 - wet_g);
            mix = wp + dp;
            // Exponent of the mix magnitude sets the dither size.
            mm = mag(mix);
            bl = 0;
            for (int i = 63; i >= 0; i--) begin
                if (mm[i]) begin
                    bl = i + 1;
                    break;
                end
            end
            e = (mm != 0) ? bl - 40 : 0;
            noise[ch] = step_noise(noise[ch]);
            d  = longint'({32'd0, noise[ch]}) - 64'sh7fffffff;
            sh = 32 - e;
            dm = mag(d) * K_DITHER;
            if (sh >= 64)
                dv = 64'd0;
            else if (sh <= 0)
                dv = dm;
            else
                dv = dm >> sh;
            mix = mix + with_sign(dv, d < 0);
            // Round half away from zero, then saturate.
            rm = (mag(mix) + 64'd65536) >> 17;
            if (mix < 0) begin
                if (rm > 64'd8388608)
                    rm = 64'd8388608;
                rm = -rm;
            end else if (rm > 64'd8388607) begin
                rm = 64'd8388607;
            end
            return rm[23:0];
        endfunction

        function void note_frame(logic [23:0] l, logic [23:0] r);
            t_frame f;
            f.left  = shape_sample(l, 0);
            f.right = shape_sample(r, 1);
            expected_frames.push_back(f);
        endfunction

        function void check_frame(logic [spsat_pkg::TDATA_W-1:0] tdata);
            t_frame want;
            if (expected_frames.size() == 0) begin
                $display("%0t unexpected item %h", $time, tdata);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            if (tdata[23:0] !== want.left) begin
                $display("%0t out_left expected %0d actual %0d", $time,
                         $signed(want.left), $signed(tdata[23:0]));
                errors++;
            end
            if (tdata[47:24] !== want.right) begin
                $display("%0t out_right expected %0d actual %0d", $time,
                         $signed(want.right), $signed(tdata[47:24]));
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [spsat_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [spsat_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                             i_s_axis_tvalid;
    logic                             o_s_axis_tready;
    logic [spsat_pkg::TDATA_W-1:0]    i_s_axis_tdata;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready;
    logic [spsat_pkg::TDATA_W-1:0]    o_m_axis_tdata;

    saturator_scoreboard sb;
    int src_idle_pct = 25;
    int snk_idle_pct = 57;
    int stall_cycles;

    stereo_polynomial_saturator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offers one frame, with random idle cycles first; called and left at a falling edge.
    task automatic push_frame(input logic [23:0] l, input logic [23:0] r);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r, l};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sb.note_frame(l, r);
        @(negedge i_clk);
    endtask

    // Stops offering items and waits for every predicted frame to come out.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_frames.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [spsat_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Gain word: zero, one, above one or in range, sometimes with junk in the upper bits.
    function automatic logic [31:0] gain_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 4))
            0: w[16:0] = 17'd0;
            1: w[16:0] = K_GAIN_ONE;
            2: w[16:0] = 17'($urandom_range(65537, 131071));
            default: w[16:0] = 17'($urandom_range(0, 65536));
        endcase
        if ($urandom_range(0, 1))
            w[31:17] = '0;
        return w;
    endfunction

    function automatic logic [31:0] seed_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'($urandom_range(1, 16385));
            2: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    // Full-scale, extreme and small samples of both signs.
    function automatic logic [23:0] rand_sample();
        logic signed [23:0] v;
        v = 24'($urandom);
        case ($urandom_range(0, 5))
            0, 1: ;
            2: begin
                case ($urandom_range(0, 4))
                    0: v = 24'h7fffff;
                    1: v = 24'h800000;
                    2: v = 24'h000000;
                    3: v = 24'h000001;
                    default: v = 24'hffffff;
                endcase
            end
            default: v = v >>> $urandom_range(1, 23);
        endcase
        return v;
    endfunction

    // Receiver readiness changes at the falling edge.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Every output item is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_frame(o_m_axis_tdata);
    end

    // Ends the run if no item moves for too long.
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("stereo_polynomial_saturator_tb: errors");
        $finish;
    end

    initial begin
        sb = new();
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: extremes, zero and the smallest steps.
        push_frame(24'h000000, 24'h000000);
        push_frame(24'h7fffff, 24'h800000);
        push_frame(24'h800000, 24'h7fffff);
        push_frame(24'h000001, 24'hffffff);
        push_frame(24'h400000, 24'hbfffff);
        settle();

        // All gains above one, a zero seed and a seed below the usual range.
        write_reg(spsat_pkg::REG_DRIVE, 32'd131071);
        write_reg(spsat_pkg::REG_LEVEL, 32'd131071);
        write_reg(spsat_pkg::REG_WET, 32'd131071);
        write_reg(spsat_pkg::REG_SEED_L, 32'd0);
        write_reg(spsat_pkg::REG_SEED_R, 32'd1);
        push_frame(24'h000000, 24'h000000);
        push_frame(24'h7fffff, 24'h800000);
        push_frame(24'h000064, 24'hffff9c);
        push_frame(24'hffffff, 24'h000001);
        settle();

        // Zero gains, fully dry, the top seed and a write to no register.
        write_reg(spsat_pkg::REG_DRIVE, 32'd0);
        write_reg(spsat_pkg::REG_LEVEL, 32'd0);
        write_reg(spsat_pkg::REG_WET, 32'd0);
        write_reg(spsat_pkg::REG_SEED_L, 32'hffffffff);
        write_reg(spsat_pkg::REG_SEED_R, 32'd16386);
        write_reg(REG_SPARE, 32'hffffffff);
        push_frame(24'h7fffff, 24'h800000);
        push_frame(24'h003039, 24'hff2bcf);
        push_frame(24'h000000, 24'h000000);
        settle();

        // Unity gains with an even mix.
        write_reg(spsat_pkg::REG_DRIVE, 32'd65536);
        write_reg(spsat_pkg::REG_LEVEL, 32'd65536);
        write_reg(spsat_pkg::REG_WET, 32'd32768);
        write_reg(spsat_pkg::REG_SEED_L, $urandom);
        write_reg(spsat_pkg::REG_SEED_R, $urandom);
        push_frame(24'h7fffff, 24'h800000);
        push_frame(24'h000001, 24'hffffff);
        push_frame(24'h0a0000, 24'hf60000);
        push_frame(24'h000010, 24'hfffff0);

        // Random part: two phases per idling pattern, each with fresh settings.
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph / 2)
                0: begin
                    src_idle_pct = 25;
                    snk_idle_pct = 57;
                end
                1: begin
                    src_idle_pct = 57;
                    snk_idle_pct = 25;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            write_reg(spsat_pkg::REG_DRIVE, gain_word());
            write_reg(spsat_pkg::REG_LEVEL, gain_word());
            write_reg(spsat_pkg::REG_WET, gain_word());
            if ($urandom_range(0, 1))
                write_reg(spsat_pkg::REG_SEED_L, seed_word());
            if ($urandom_range(0, 1))
                write_reg(spsat_pkg::REG_SEED_R, seed_word());
            repeat (75)
                push_frame(rand_sample(), rand_sample());
        end

        settle();
        repeat (40) @(negedge i_clk);
        if (sb.errors == 0 && sb.expected_frames.size() == 0)
            $display("stereo_polynomial_saturator_tb: clean");
        else
            $display("stereo_polynomial_saturator_tb: errors");
        $finish;
    end

endmodule
